/* sv/ght_pkg.sv */
// Package for the generational handle table: types, codes and sizes.
`timescale 1ns / 1ps
package ght_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam int KEY_W = 64;
    localparam int GEN_W = 32;

    localparam logic [2:0] OP_ACQUIRE    = 3'd0;
    localparam logic [2:0] OP_RESOLVE    = 3'd1;
    localparam logic [2:0] OP_INVALIDATE = 3'd2;
    localparam logic [2:0] OP_RELEASE    = 3'd3;
    localparam logic [2:0] OP_RESET      = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_STALE   = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_MATCH_RD, S_MATCH_CHK, S_FREE_RD, S_FREE_CHK,
        S_APPEND, S_RES_RD, S_RES_CHK, S_SWEEP_RD, S_SWEEP_CHK, S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;       // capture request
        logic       clr_idx;    // scan index to zero
        logic       inc_idx;
        logic       set_qidx;   // scan index from query
        logic       rd;         // read slot at scan index
        logic       wr_acq;     // write key/kind, gen+1
        logic       wr_append;
        logic       wr_free;    // clear key, gen+1
        logic       used_inc;
        logic       used_clr;
        logic       set_res;    // load result register
        logic [1:0] res_st;
        logic       res_idx;    // result carries slot index/gen
        logic       res_key;    // result carries read key
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       key_zero;
        logic       kind_zero;
        logic       qvalid;
        logic       idx_end;    // scan index reached slots_used
        logic       q_in_range;
        logic       full;
        logic       hit;        // read slot kind and key match
        logic       rd_free;    // read slot key zero
        logic       res_ok;     // resolve checks pass
    } t_stat;
endpackage

/* sv/ght_datapath.sv */
// Datapath: slot memory, scan index, request and result registers.
`timescale 1ns / 1ps
module ght_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ght_pkg::t_cmd         i_cmd,
    output ght_pkg::t_stat        o_stat,
    input  logic [2:0]            i_opcode,
    input  logic [1:0]            i_kind,
    input  logic [63:0]           i_key,
    input  logic                  i_qvalid,
    input  logic [5:0]            i_qidx,
    input  logic [31:0]           i_qgen,
    output logic [1:0]            o_status,
    output logic [5:0]            o_slot_index,
    output logic [31:0]           o_slot_generation,
    output logic [63:0]           o_resolved_key
);
    import ght_pkg::*;

    // slot memory, one entry packs key, kind, generation
    localparam int ENT_W = KEY_W + 2 + GEN_W;
    logic [ENT_W-1:0] mem [TABLE_DEPTH];

    logic [2:0]       r_op;
    logic [1:0]       r_kind;
    logic [KEY_W-1:0] r_key;
    logic             r_qvalid;
    logic [5:0]       r_qidx;
    logic [GEN_W-1:0] r_qgen;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_used;
    logic [ENT_W-1:0] r_rd;

    logic [KEY_W-1:0] rd_key;
    logic [1:0]       rd_kind;
    logic [GEN_W-1:0] rd_gen;
    logic [GEN_W-1:0] wr_gen;
    logic [IDX_W-1:0] addr;
    logic [CNT_W-1:0] qidx_ext;

    assign rd_key  = r_rd[ENT_W-1 -: KEY_W];
    assign rd_kind = r_rd[GEN_W +: 2];
    assign rd_gen  = r_rd[GEN_W-1:0];
    assign addr    = r_idx[IDX_W-1:0];
    assign wr_gen  = i_cmd.wr_append ? GEN_W'(1) : rd_gen + GEN_W'(1);
    assign qidx_ext = CNT_W'(r_qidx);

    // request capture and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_idx  <= '0;
        end else begin
            if (i_cmd.used_clr)      r_used <= '0;
            else if (i_cmd.used_inc) r_used <= r_used + CNT_W'(1);
            if (i_cmd.clr_idx)       r_idx <= '0;
            else if (i_cmd.set_qidx) r_idx <= qidx_ext;
            else if (i_cmd.inc_idx)  r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_kind   <= i_kind;
            r_key    <= i_key;
            r_qvalid <= i_qvalid;
            r_qidx   <= i_qidx;
            r_qgen   <= i_qgen;
        end
    end

    // memory port: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_acq || i_cmd.wr_append)
            mem[addr] <= {r_key, r_kind, wr_gen};
        else if (i_cmd.wr_free)
            mem[addr] <= {{KEY_W{1'b0}}, rd_kind, rd_gen + GEN_W'(1)};
        if (i_cmd.rd)
            r_rd <= mem[addr];
    end

    // result register; an existing slot reports its stored generation
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            o_status          <= i_cmd.res_st;
            o_slot_index      <= i_cmd.res_idx ? 6'(r_idx) : 6'd0;
            o_slot_generation <= !i_cmd.res_idx ? '0 :
                                 (i_cmd.wr_acq || i_cmd.wr_append) ? wr_gen : rd_gen;
            o_resolved_key    <= i_cmd.res_key ? rd_key : '0;
        end
    end

    always_comb begin
        o_stat.opcode     = r_op;
        o_stat.key_zero   = (r_key == '0);
        o_stat.kind_zero  = (r_kind == 2'd0);
        o_stat.qvalid     = r_qvalid;
        o_stat.idx_end    = (r_idx >= r_used);
        o_stat.q_in_range = (qidx_ext < r_used);
        o_stat.full       = (r_used == CNT_W'(TABLE_DEPTH));
        o_stat.hit        = (rd_kind == r_kind) && (rd_key == r_key);
        o_stat.rd_free    = (rd_key == '0);
        o_stat.res_ok     = (rd_kind == r_kind) && (rd_gen == r_qgen) && (rd_key != '0);
    end
endmodule

/* sv/ght_ctrl.sv */
// Controller: sequences each request through scans of the slot memory.
`timescale 1ns / 1ps
module ght_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  ght_pkg::t_stat i_stat,
    output ght_pkg::t_cmd  o_cmd
);
    import ght_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_st  = ST_OK;
                n_state       = S_DONE;
                case (i_stat.opcode)
                    OP_ACQUIRE: begin
                        if (i_stat.key_zero) o_cmd.res_st = ST_INVALID;
                        else begin
                            o_cmd.set_res = 1'b0;
                            n_state       = S_MATCH_RD;
                        end
                    end
                    OP_RESOLVE: begin
                        if (!i_stat.qvalid || !i_stat.q_in_range)
                            o_cmd.res_st = ST_INVALID;
                        else begin
                            o_cmd.set_res  = 1'b0;
                            o_cmd.set_qidx = 1'b1;
                            n_state        = S_RES_RD;
                        end
                    end
                    OP_INVALIDATE: begin
                        if (i_stat.key_zero || i_stat.kind_zero)
                            o_cmd.res_st = ST_INVALID;
                        else n_state = S_SWEEP_RD;
                    end
                    OP_RELEASE: n_state = S_SWEEP_RD;
                    OP_RESET:   o_cmd.used_clr = 1'b1;
                    default:    o_cmd.res_st = ST_INVALID;
                endcase
            end
            // first pass: existing slot with same kind and key
            S_MATCH_RD: begin
                if (i_stat.idx_end) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state       = S_FREE_RD;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_MATCH_CHK;
                end
            end
            S_MATCH_CHK: begin
                if (i_stat.hit) begin
                    // existing slot: generation reported unchanged
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = ST_OK;
                    o_cmd.res_idx = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_MATCH_RD;
                end
            end
            // second pass: lowest free slot
            S_FREE_RD: begin
                if (i_stat.idx_end) n_state = S_APPEND;
                else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                if (i_stat.rd_free) begin
                    o_cmd.wr_acq  = 1'b1;
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_st  = ST_OK;
                    o_cmd.res_idx = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_FREE_RD;
                end
            end
            S_APPEND: begin
                o_cmd.set_res = 1'b1;
                n_state       = S_DONE;
                if (i_stat.full) o_cmd.res_st = ST_FULL;
                else begin
                    o_cmd.wr_append = 1'b1;
                    o_cmd.used_inc  = 1'b1;
                    o_cmd.res_st    = ST_OK;
                    o_cmd.res_idx   = 1'b1;
                end
            end
            S_RES_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RES_CHK;
            end
            S_RES_CHK: begin
                o_cmd.set_res = 1'b1;
                n_state       = S_DONE;
                if (i_stat.res_ok) begin
                    o_cmd.res_st  = ST_OK;
                    o_cmd.res_key = 1'b1;
                end else o_cmd.res_st = ST_STALE;
            end
            // invalidate or release-all over every used slot
            S_SWEEP_RD: begin
                if (i_stat.idx_end) n_state = S_DONE;
                else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_SWEEP_CHK;
                end
            end
            S_SWEEP_CHK: begin
                o_cmd.inc_idx = 1'b1;
                n_state       = S_SWEEP_RD;
                if (i_stat.opcode == OP_RELEASE) o_cmd.wr_free = !i_stat.rd_free;
                else                             o_cmd.wr_free = i_stat.hit;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* sv/generational_handle_table_top.sv */
// Top level: generational handle table with stream request and result ports.
// Reset-table and invalid requests finish at dispatch; resolve reads one slot; acquire
// scans the used slots for a match, then for a free slot, then appends; invalidate and
// release-all sweep the used slots; at most 64 slots are in use. One request at a time:
// the next is taken in the cycle after the result leaves. The single-port scan reads a
// slot, then checks it. Reset (i_rst_n low, sync) empties the table.
`timescale 1ns / 1ps
module generational_handle_table_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[2:0], handle_kind[4:3], object_key[68:5], query_valid[69],
    // query_index[75:70], query_generation[107:76], zero fill
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], slot_index[7:2], slot_generation[39:8],
    // resolved_key[103:40]
    output logic [103:0] m_axis_tdata
);
    import ght_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic [1:0]  status;
    logic [5:0]  slot_index;
    logic [31:0] slot_gen;
    logic [63:0] rkey;

    ght_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    ght_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_opcode(s_axis_tdata[2:0]), .i_kind(s_axis_tdata[4:3]),
        .i_key(s_axis_tdata[68:5]), .i_qvalid(s_axis_tdata[69]),
        .i_qidx(s_axis_tdata[75:70]), .i_qgen(s_axis_tdata[107:76]),
        .o_status(status), .o_slot_index(slot_index),
        .o_slot_generation(slot_gen), .o_resolved_key(rkey)
    );

    assign m_axis_tdata = {rkey, slot_gen, slot_index, status};

    // checks
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_one_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.wr_acq, cmd.wr_append, cmd.wr_free})) else $error("write clash");
    a_key_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_OK |-> m_axis_tdata[103:40] == '0)
        else $error("key on failed result");
endmodule

/* dv/testbench.sv */
// Self-checking testbench for the generational handle table top level.
`timescale 1ns / 1ps
module testbench;
    import ght_pkg::*;

    // field order matches the result bus, status in the low bits
    typedef struct packed {
        logic [63:0] resolved_key;
        logic [31:0] slot_generation;
        logic [5:0]  slot_index;
        logic [1:0]  status;
    } t_reply;

    // Mirror of the slot table; predicts one reply per request
    class handle_table_sb;
        logic [63:0] key_q[TABLE_DEPTH];
        logic [1:0]  kind_q[TABLE_DEPTH];
        logic [31:0] gen_q[TABLE_DEPTH];
        int          used;
        t_reply      pending[$];
        int          errors;
        int          checked;

        function new();
            used = 0;
            errors = 0;
            checked = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                key_q[i] = '0;
                kind_q[i] = '0;
                gen_q[i] = '0;
            end
        endfunction

        function void note_request(logic [2:0] op, logic [1:0] kind, logic [63:0] key,
                                   logic qv, logic [5:0] qi, logic [31:0] qg);
            t_reply r;
            bit done;
            r = '0;
            r.status = ST_OK;
            done = 0;
            case (op)
                OP_ACQUIRE: begin
                    if (key == 0) begin
                        r.status = ST_INVALID;
                        done = 1;
                    end
                    for (int i = 0; i < used && !done; i++)
                        if (kind_q[i] == kind && key_q[i] == key) begin
                            r.slot_index = 6'(i);
                            r.slot_generation = gen_q[i];
                            done = 1;
                        end
                    for (int i = 0; i < used && !done; i++)
                        if (key_q[i] == 0) begin
                            key_q[i] = key;
                            kind_q[i] = kind;
                            gen_q[i] = gen_q[i] + 32'd1;
                            r.slot_index = 6'(i);
                            r.slot_generation = gen_q[i];
                            done = 1;
                        end
                    if (!done) begin
                        if (used >= TABLE_DEPTH) begin
                            r.status = ST_FULL;
                        end else begin
                            key_q[used] = key;
                            kind_q[used] = kind;
                            gen_q[used] = 32'd1;
                            r.slot_index = 6'(used);
                            r.slot_generation = 32'd1;
                            used++;
                        end
                    end
                end
                OP_RESOLVE: begin
                    if (!qv || qi >= used)
                        r.status = ST_INVALID;
                    else if (kind_q[qi] != kind || gen_q[qi] != qg || key_q[qi] == 0)
                        r.status = ST_STALE;
                    else
                        r.resolved_key = key_q[qi];
                end
                OP_INVALIDATE: begin
                    if (kind == 0 || key == 0)
                        r.status = ST_INVALID;
                    else
                        for (int i = 0; i < used; i++)
                            if (kind_q[i] == kind && key_q[i] == key) begin
                                key_q[i] = 0;
                                gen_q[i] = gen_q[i] + 32'd1;
                            end
                end
                OP_RELEASE: begin
                    for (int i = 0; i < used; i++)
                        if (key_q[i] != 0) begin
                            key_q[i] = 0;
                            gen_q[i] = gen_q[i] + 32'd1;
                        end
                end
                OP_RESET: used = 0;
                default: r.status = ST_INVALID;
            endcase
            pending = {pending, r};
        endfunction

        function void check_reply(t_reply got);
            t_reply exp;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected reply %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: status %0d/%0d idx %0d/%0d gen %h/%h key %h/%h",
                             exp.status, got.status, exp.slot_index, got.slot_index,
                             exp.slot_generation, got.slot_generation,
                             exp.resolved_key, got.resolved_key);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    handle_table_sb sb;
    bit             calm;      // no idling in the last stretch
    int             cycles;
    int             stall_left;
    logic [63:0]    key_pool[8];
    logic [5:0]     last_idx;
    logic [31:0]    last_gen;
    logic [1:0]     last_kind;

    generational_handle_table_top dut (.*);

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: random stalls, check on handshake
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_reply(m_axis_tdata);
            if (m_axis_tdata[7:2] != 0 && m_axis_tdata[1:0] == ST_OK) begin
                last_idx <= m_axis_tdata[7:2];
                last_gen <= m_axis_tdata[39:8];
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // one request, with an optional idle burst before it
    task automatic send(logic [2:0] op, logic [1:0] kind, logic [63:0] key,
                        logic qv, logic [5:0] qi, logic [31:0] qg);
        int gap;
        gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 5) : 0;
        repeat (gap) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, qg, qi, qv, key, kind, op};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(op, kind, key, qv, qi, qg);
        s_axis_tvalid <= 1'b0;
        // the block is busy after it takes a request
        @(posedge i_clk);
    endtask

    task automatic rand_request();
        int pick;
        logic [1:0] kind;
        logic [63:0] key;
        pick = $urandom_range(0, 99);
        kind = 2'($urandom_range(0, 3));
        key = key_pool[$urandom_range(0, 7)];
        if (pick < 40)
            send(OP_ACQUIRE, kind, ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : key,
                 1'($urandom), 6'($urandom), $urandom);
        else if (pick < 65)
            send(OP_RESOLVE, ($urandom_range(0, 1)) ? last_kind : kind, {$urandom, $urandom},
                 $urandom_range(0, 9) != 0,
                 ($urandom_range(0, 1)) ? last_idx : 6'($urandom),
                 ($urandom_range(0, 3) != 0) ? last_gen : 32'($urandom));
        else if (pick < 85)
            send(OP_INVALIDATE, kind, key, 1'($urandom), 6'($urandom), $urandom);
        else if (pick < 91)
            send(OP_RELEASE, kind, key, 1'($urandom), 6'($urandom), $urandom);
        else if (pick < 95)
            send(OP_RESET, kind, key, 1'($urandom), 6'($urandom), $urandom);
        else
            send(3'($urandom_range(5, 7)), kind, key, 1'($urandom), 6'($urandom), $urandom);
        last_kind = kind;
    endtask

    initial begin
        sb = new();
        calm = 0;
        cycles = 0;
        stall_left = 0;
        last_idx = 0;
        last_gen = 1;
        last_kind = 1;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        for (int i = 0; i < 8; i++)
            key_pool[i] = {$urandom, $urandom} | 64'h1;
        key_pool[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        key_pool[1] = 64'h1;
        key_pool[2] = 64'h0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: null key, kinds, reuse, stale, bad opcodes, full table
        send(OP_RESOLVE, 1, 0, 1, 0, 0);
        send(OP_ACQUIRE, 1, 0, 0, 0, 0);
        send(OP_ACQUIRE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send(OP_ACQUIRE, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0);
        send(OP_ACQUIRE, 3, 64'h1, 0, 0, 0);
        send(OP_RESOLVE, 3, 0, 1, 1, 1);
        send(OP_RESOLVE, 2, 0, 1, 1, 1);
        send(OP_RESOLVE, 3, 0, 1, 1, 2);
        send(OP_RESOLVE, 3, 0, 0, 1, 1);
        send(OP_RESOLVE, 3, 0, 1, 63, 32'hFFFF_FFFF);
        send(OP_INVALIDATE, 0, 64'h1, 0, 0, 0);
        send(OP_INVALIDATE, 3, 0, 0, 0, 0);
        send(OP_INVALIDATE, 2, 64'h1, 0, 0, 0);
        send(OP_INVALIDATE, 3, 64'h1, 0, 0, 0);
        send(OP_RESOLVE, 3, 0, 1, 1, 2);
        send(OP_ACQUIRE, 2, 64'h5, 0, 0, 0);
        send(OP_RELEASE, 0, 0, 0, 0, 0);
        for (int i = 0; i < 64; i++)
            send(OP_ACQUIRE, 1, 64'h100 + i, 0, 0, 0);
        send(OP_ACQUIRE, 1, 64'h9999, 0, 0, 0);
        send(OP_RESOLVE, 1, 0, 1, 63, 1);
        send(3'd5, 1, 1, 1, 1, 1);
        send(3'd7, 3, 64'hFFFF_FFFF_FFFF_FFFF, 1, 63, 32'hFFFF_FFFF);
        send(OP_RESET, 0, 0, 0, 0, 0);
        send(OP_ACQUIRE, 1, 64'h7, 0, 0, 0);

        // random traffic; the last part runs without idling
        for (int n = 0; n < 1550; n++) begin
            if (n == 1350)
                calm = 1;
            rand_request();
        end

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("covered %0d replies: acquire/reuse/append/full, resolve, invalidate,",
                 sb.checked);
        $display("release-all, table reset and unknown opcodes under random stalls");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

/* sim.f */
sv/ght_pkg.sv
sv/ght_datapath.sv
sv/ght_ctrl.sv
sv/generational_handle_table_top.sv
dv/testbench.sv
